/* hdl/vlmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlmc_pkg
// Shared types, constants and the neighbour probe table of the volume
// local maximum check.
// ----------------------------------------------------------------------------
package vlmc_pkg;

    // plane store geometry
    localparam int PLANE_PIXELS = 16384;
    localparam int PLANE_SLOTS  = 8;
    localparam int ADDR_W       = $clog2(PLANE_PIXELS);
    localparam int SLOT_W       = $clog2(PLANE_SLOTS);
    localparam int MEM_DEPTH    = PLANE_SLOTS * PLANE_PIXELS;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);

    // field widths
    localparam int PLANE_W = 10;
    localparam int PIXEL_W = 14;
    localparam int DIM_W   = 15;
    localparam int COUNT_W = 15;
    localparam int VALUE_W = 32;
    localparam int AREA_W  = 2 * DIM_W;

    // signed plane number with room for offsets of -3 to +3
    localparam int PLANE_CALC_W = PLANE_W + 2;
    // signed pixel address: pixel plus or minus one row
    localparam int PIX_CALC_W   = ((PIXEL_W > DIM_W) ? PIXEL_W : DIM_W) + 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(16384);

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // register indexes
    localparam logic [1:0] REG_PLANE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PLANE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_NB_MODE      = 2'd2;
    localparam logic [1:0] REG_FRAMES       = 2'd3;

    // neighbourhood modes
    localparam logic MODE_FIVE  = 1'b0;
    localparam logic MODE_SEVEN = 1'b1;

    // probe sequence: centre value first, then the neighbours
    localparam int FIVE_STEPS  = 13;
    localparam int SEVEN_STEPS = 21;
    localparam int STEP_W      = $clog2(SEVEN_STEPS);

    typedef struct packed {
        logic                     cmd;
        logic [PLANE_W-1:0]       plane_number;
        logic [PIXEL_W-1:0]       pixel_index;
        logic signed [VALUE_W-1:0] sample_value;
        logic                     last_candidate;
    } req_t;

    typedef struct packed {
        logic               is_maximum;
        logic [PIXEL_W-1:0] kept_index;
        logic [COUNT_W-1:0] kept_count;
        logic               run_done;
    } res_t;

    typedef struct packed {
        logic                           en;
        logic signed [PLANE_CALC_W-1:0] plane;
        logic signed [PIX_CALC_W-1:0]   addr;
    } store_rd_t;

    typedef struct packed {
        logic                      en;
        logic [PLANE_W-1:0]        plane;
        logic [PIXEL_W-1:0]        pixel;
        logic signed [VALUE_W-1:0] data;
    } store_wr_t;

    typedef enum logic [2:0] {
        NB_CENTRE,
        NB_LEFT,
        NB_RIGHT,
        NB_UP,
        NB_DOWN
    } nb_pos_t;

    typedef struct packed {
        logic signed [2:0] plane_off;
        nb_pos_t           pos;
    } probe_t;

    function automatic probe_t cross_probe(logic signed [2:0] off, int sel, logic skip_up);
        probe_t p;
        p.plane_off = off;
        p.pos       = NB_CENTRE;
        if (skip_up)
        begin
            case (sel)
                1:       p.pos = NB_LEFT;
                2:       p.pos = NB_RIGHT;
                3:       p.pos = NB_DOWN;
                default: p.pos = NB_CENTRE;
            endcase
        end
        else
        begin
            case (sel)
                1:       p.pos = NB_LEFT;
                2:       p.pos = NB_RIGHT;
                3:       p.pos = NB_UP;
                4:       p.pos = NB_DOWN;
                default: p.pos = NB_CENTRE;
            endcase
        end
        return p;
    endfunction

    function automatic probe_t probe_at(logic mode, logic [STEP_W-1:0] step);
        probe_t p;
        int     s;
        s = int'(step);
        p.plane_off = 3'sd0;
        p.pos       = NB_CENTRE;
        if (mode == MODE_FIVE)
        begin
            if (s == 1)
                p.plane_off = -3'sd2;
            else if (s == 2)
                p.plane_off = 3'sd2;
            else if (s >= 3 && s <= 7)
                p = cross_probe(-3'sd1, s - 3, 1'b0);
            else if (s >= 8 && s <= 12)
                p = cross_probe(3'sd1, s - 8, 1'b0);
        end
        else
        begin
            if (s == 1)
                p.plane_off = -3'sd3;
            else if (s == 2)
                p.plane_off = 3'sd3;
            else if (s >= 3 && s <= 7)
                p = cross_probe(-3'sd2, s - 3, 1'b0);
            else if (s >= 8 && s <= 12)
                p = cross_probe(3'sd1, s - 8, 1'b0);
            else if (s >= 13 && s <= 16)
                p = cross_probe(-3'sd1, s - 13, 1'b1);
            else if (s >= 17 && s <= 20)
                p = cross_probe(3'sd2, s - 17, 1'b1);
        end
        return p;
    endfunction

endpackage

/* hdl/vlmc_plane_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlmc_plane_store
// Ring of plane slots in one synchronous memory. Maps plane numbers onto
// slots and returns zero for planes outside the volume or pixels beyond
// the plane. One write and one read a cycle; read data is registered.
// ----------------------------------------------------------------------------
module vlmc_plane_store
(
    input  logic                                clk,
    input  logic [vlmc_pkg::PLANE_W-1:0]        frames,
    input  vlmc_pkg::store_wr_t                 wr,
    input  vlmc_pkg::store_rd_t                 rd,
    output logic signed [vlmc_pkg::VALUE_W-1:0] rd_value
);
    import vlmc_pkg::*;

    logic signed [VALUE_W-1:0] mem [MEM_DEPTH];

    logic signed [VALUE_W-1:0] rd_q_reg;
    logic                      rd_zero_reg;

    logic                      wr_in_plane;
    logic [SLOT_W-1:0]         wr_slot;
    logic [MEM_AW-1:0]         wr_idx;

    logic                      rd_in_volume;
    logic                      rd_in_plane;
    logic [PLANE_CALC_W-1:0]   rd_plane_u;
    logic [SLOT_W-1:0]         rd_slot;
    logic [MEM_AW-1:0]         rd_idx;

    always_comb
    begin
        wr_in_plane = int'(wr.pixel) < PLANE_PIXELS;
        wr_slot     = SLOT_W'(wr.plane % PLANE_SLOTS);
        wr_idx      = MEM_AW'(wr_slot) * MEM_AW'(PLANE_PIXELS)
                    + MEM_AW'(ADDR_W'(wr.pixel));

        rd_plane_u   = rd.plane;
        rd_in_volume = (rd.plane >= 0)
                    && (rd.plane < $signed({2'b00, frames}));
        rd_in_plane  = (rd.addr >= 0) && (int'(rd.addr) < PLANE_PIXELS);
        rd_slot      = SLOT_W'(rd_plane_u % PLANE_SLOTS);
        rd_idx       = MEM_AW'(rd_slot) * MEM_AW'(PLANE_PIXELS)
                     + MEM_AW'(ADDR_W'($unsigned(rd.addr)));
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_in_plane)
        begin
            mem[wr_idx] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_q_reg    <= mem[rd_idx];
            rd_zero_reg <= !(rd_in_volume && rd_in_plane);
        end
    end

    assign rd_value = rd_zero_reg ? '0 : rd_q_reg;

endmodule

/* hdl/volume_local_max_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_local_max_check
// Three-dimensional non-maximum suppression over a ring of stored planes.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid / req_stall / req_data. A write request
//   stores one sample at a plane and pixel in the accepting cycle and gives
//   no result. A check request tests one candidate pixel against its
//   neighbours on nearby planes and gives one result on res_valid /
//   res_stall / res_data.
//   A write leaves the block idle, so writes can run back to back. A check
//   reads the centre value and each neighbour in turn through the single
//   read port of the plane store, one read a cycle: 13 reads in five-plane
//   mode, 21 in seven-plane mode. A check runs through ST_BOUNDS, ST_READ,
//   ST_DRAIN and ST_FINISH, which registers the result; an out-of-bounds
//   candidate skips to ST_FINISH. Requests are stalled outside ST_IDLE.
//   The result sits in an output register, so further requests are taken
//   while it waits; a finished check waits only when the previous result is
//   still stalled. Reset clears the control state, the kept counter and
//   the registers to their defaults; plane contents are undefined until
//   written. Registers are written through cfg_write / cfg_index / cfg_data;
//   the user must write them only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module volume_local_max_check
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  vlmc_pkg::req_t                 req_data,
    output logic                           res_valid,
    input  logic                           res_stall,
    output vlmc_pkg::res_t                 res_data,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [vlmc_pkg::DIM_W-1:0]     cfg_data
);
    import vlmc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                    state_reg;

    logic [DIM_W-1:0]          width_reg;
    logic [DIM_W-1:0]          height_reg;
    logic                      mode_reg;
    logic [PLANE_W-1:0]        frames_reg;
    logic [AREA_W-1:0]         area_reg;

    logic [PLANE_W-1:0]        plane_reg;
    logic [PIXEL_W-1:0]        pix_reg;
    logic                      last_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      keep_reg;
    logic signed [VALUE_W-1:0] centre_reg;
    logic                      rd_pending_reg;
    logic                      rd_centre_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      res_valid_reg;
    res_t                      res_data_reg;

    logic                      req_accept;
    logic                      res_free;
    probe_t                    probe;
    logic [STEP_W-1:0]         last_step;
    logic [AREA_W-1:0]         upper_bound;
    logic                      in_bounds;
    logic [COUNT_W-1:0]        count_next;
    logic signed [VALUE_W-1:0] rd_value;
    logic signed [PIX_CALC_W-1:0] pix_base;
    logic signed [PIX_CALC_W-1:0] row_step;
    store_rd_t                 rd;
    store_wr_t                 wr;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign res_free   = !res_valid_reg || !res_stall;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    always_comb
    begin
        probe     = probe_at(mode_reg, step_reg);
        last_step = (mode_reg == MODE_SEVEN) ? STEP_W'(SEVEN_STEPS - 1)
                                             : STEP_W'(FIVE_STEPS - 1);

        upper_bound = (area_reg >= AREA_W'(width_reg))
                    ? area_reg - AREA_W'(width_reg) : '0;
        in_bounds   = (AREA_W'(pix_reg) > AREA_W'(width_reg))
                   && (AREA_W'(pix_reg) < upper_bound);

        count_next = (keep_reg && (count_reg < COUNT_MAX))
                   ? count_reg + COUNT_W'(1) : count_reg;

        pix_base = $signed(PIX_CALC_W'(pix_reg));
        row_step = $signed(PIX_CALC_W'(width_reg));

        rd.en    = (state_reg == ST_READ);
        rd.plane = $signed({2'b00, plane_reg})
                 + $signed({{(PLANE_CALC_W-3){probe.plane_off[2]}}, probe.plane_off});
        unique case (probe.pos)
            NB_LEFT:  rd.addr = pix_base - PIX_CALC_W'(1);
            NB_RIGHT: rd.addr = pix_base + PIX_CALC_W'(1);
            NB_UP:    rd.addr = pix_base - row_step;
            NB_DOWN:  rd.addr = pix_base + row_step;
            default:  rd.addr = pix_base;
        endcase

        wr.en    = req_accept && (req_data.cmd == CMD_WRITE);
        wr.plane = req_data.plane_number;
        wr.pixel = req_data.pixel_index;
        wr.data  = req_data.sample_value;
    end

    vlmc_plane_store u_store
    (
        .clk      (clk),
        .frames   (frames_reg),
        .wr       (wr),
        .rd       (rd),
        .rd_value (rd_value)
    );

    // configuration registers and the derived plane area
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(128);
            height_reg <= DIM_W'(128);
            mode_reg   <= MODE_FIVE;
            frames_reg <= PLANE_W'(32);
            area_reg   <= AREA_W'(16384);
        end
        else
        begin
            area_reg <= AREA_W'(width_reg) * AREA_W'(height_reg);
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_PLANE_WIDTH:  width_reg  <= cfg_data;
                    REG_PLANE_HEIGHT: height_reg <= cfg_data;
                    REG_NB_MODE:      mode_reg   <= cfg_data[0];
                    REG_FRAMES:       frames_reg <= cfg_data[PLANE_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // request payload and compare path
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            plane_reg <= req_data.plane_number;
            pix_reg   <= req_data.pixel_index;
            last_reg  <= req_data.last_candidate;
        end
        if (rd_pending_reg && rd_centre_reg)
        begin
            centre_reg <= rd_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            keep_reg       <= 1'b0;
            rd_pending_reg <= 1'b0;
            rd_centre_reg  <= 1'b0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_data_reg   <= '0;
        end
        else
        begin
            rd_pending_reg <= rd.en;
            rd_centre_reg  <= (step_reg == '0);

            // fold each returned neighbour into the verdict
            if (rd_pending_reg && !rd_centre_reg)
            begin
                keep_reg <= keep_reg && (centre_reg > rd_value);
            end

            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_accept && (req_data.cmd == CMD_CHECK))
                    begin
                        state_reg <= ST_BOUNDS;
                    end
                end
                ST_BOUNDS:
                begin
                    step_reg <= '0;
                    keep_reg <= in_bounds;
                    state_reg <= in_bounds ? ST_READ : ST_FINISH;
                end
                ST_READ:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == last_step)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    // hold until the output register is free
                    if (res_free)
                    begin
                        res_valid_reg           <= 1'b1;
                        res_data_reg.is_maximum <= keep_reg;
                        res_data_reg.kept_index <= pix_reg;
                        res_data_reg.kept_count <= count_next;
                        res_data_reg.run_done   <= last_reg;
                        count_reg <= last_reg ? '0 : count_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
